// File: hw/rtl/srle_pkg.sv
package srle_pkg;

  localparam int PIX_W  = 8;
  localparam int CHAR_W = 7;
  localparam int LEN_W  = 11;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'd0;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 7'h3f;

  localparam logic [7:0] ASCII_DOLLAR = 8'h24;
  localparam logic [7:0] ASCII_DASH   = 8'h2d;
  localparam logic [7:0] ASCII_HASH   = 8'h23;
  localparam logic [7:0] ASCII_BANG   = 8'h21;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_TWO    = 8'h32;
  localparam logic [7:0] ASCII_FIVE   = 8'h35;

  // longest run that goes out as one repeat token
  localparam logic [LEN_W-1:0] CHUNK_LEN = 11'd255;
  // shortest run that uses a repeat token
  localparam logic [LEN_W-1:0] MIN_REPEAT = 11'd4;

  // work for the back end: optional prefix, up to two runs, optional row end
  typedef struct packed {
    logic                        nl;
    logic                        pm;
    logic [PIX_W-1:0]            pen;
    logic [1:0]                  rv;
    logic [1:0][CHAR_W-1:0]      rch;
    logic [1:0][LEN_W-1:0]       rlen;
    logic                        dash;
  } cmd_t;

  typedef struct packed {
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] u;
  } digits_t;

  // decimal digits of an 8-bit value, tens by reciprocal multiply
  function automatic digits_t dec3(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  u;
    digits_t     d;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end else begin
      h = 2'd0;
      r = v;
    end
    p = 15'(r) * 15'd205;
    t = p[14:11];
    u = r - ({4'b0, t} * 8'd10);
    d.h = {2'b0, h};
    d.t = t;
    d.u = u[3:0];
    return d;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return ASCII_ZERO | {4'b0, d};
  endfunction

endpackage

// File: hw/rtl/srle_if.sv
interface srle_col_if;
  logic       valid;
  logic       ready;
  logic [7:0] pen;
  logic [7:0] pixel_0;
  logic [7:0] pixel_1;
  logic [7:0] pixel_2;
  logic [7:0] pixel_3;
  logic [7:0] pixel_4;
  logic [7:0] pixel_5;
  logic       first_in_pass;
  logic       last_in_pass;
  logic       first_pass_of_row;
  logic       last_pass_of_row;
  logic       force_full_width;

  modport source (
    output valid, pen, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
           first_in_pass, last_in_pass, first_pass_of_row, last_pass_of_row,
           force_full_width,
    input  ready
  );
  modport sink (
    input  valid, pen, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
           first_in_pass, last_in_pass, first_pass_of_row, last_pass_of_row,
           force_full_width,
    output ready
  );
endinterface

interface srle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;

  modport source (output valid, out_byte, last_of_item, input ready);
  modport sink (input valid, out_byte, last_of_item, output ready);
endinterface

// File: hw/rtl/srle_front.sv
module srle_front import srle_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  srle_col_if.sink         col,
  input  logic [PIX_W-1:0] transparent_pen,
  input  logic             q_full,
  output logic             push,
  output cmd_t             cmd
);

  localparam int RunCap = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [CHAR_W-1:0] run_char, run_char_next;
  logic [LEN_W-1:0]  run_length, run_length_next;
  logic              need_newline_mark, need_newline_mark_next;
  logic              row_has_output, row_has_output_next;
  logic              need_pen_mark, need_pen_mark_next;
  logic              force_pending, force_pending_next;

  logic              accept, row_start, opaque, f1, f2, any_flush, dash;
  logic              nl_a, rho_a, fp_a, pm_a;
  logic [CHAR_W-1:0] rc_a, rc_b, ch;
  logic [LEN_W-1:0]  rl_a, rl_b;
  logic [5:0]        mask;

  assign col.ready = !q_full;
  assign accept    = col.valid && !q_full;

  always_comb begin
    row_start = col.first_in_pass && col.first_pass_of_row;
    nl_a  = row_start ? 1'b0 : need_newline_mark;
    rho_a = row_start ? 1'b0 : row_has_output;
    fp_a  = row_start ? col.force_full_width : force_pending;
    rc_a  = col.first_in_pass ? CHAR_NONE : run_char;
    rl_a  = col.first_in_pass ? '0 : run_length;
    pm_a  = col.first_in_pass ? 1'b1 : need_pen_mark;

    opaque  = col.pen != transparent_pen;
    mask[0] = col.pixel_0 == col.pen;
    mask[1] = col.pixel_1 == col.pen;
    mask[2] = col.pixel_2 == col.pen;
    mask[3] = col.pixel_3 == col.pen;
    mask[4] = col.pixel_4 == col.pen;
    mask[5] = col.pixel_5 == col.pen;
    ch      = CHAR_BLANK + {1'b0, mask};

    // a new character closes the open run
    f1 = opaque && (rc_a != CHAR_NONE) && (rc_a != ch);
    rc_b = rc_a;
    rl_b = rl_a;
    if (opaque) begin
      if (rc_a == ch) begin
        if (rl_a < LEN_W'(RunCap)) rl_b = rl_a + 1'b1;
      end else begin
        rc_b = ch;
        rl_b = 11'd1;
      end
    end

    // end of pass: trailing blank run only goes out when forced
    f2 = opaque && col.last_in_pass && ((rc_b != CHAR_BLANK) || fp_a);
    any_flush = f1 || f2;
    dash = col.last_in_pass && col.last_pass_of_row;

    cmd.nl      = any_flush && nl_a;
    cmd.pm      = any_flush && pm_a;
    cmd.pen     = col.pen;
    cmd.rv      = {f2, f1};
    cmd.rch     = {rc_b, rc_a};
    cmd.rlen    = {rl_b, rl_a};
    cmd.dash    = dash;

    need_newline_mark_next = nl_a && !any_flush;
    need_pen_mark_next     = pm_a && !any_flush;
    row_has_output_next    = rho_a || any_flush;
    run_char_next          = rc_b;
    run_length_next        = rl_b;
    force_pending_next     = fp_a && !f2;
    if (opaque && col.last_in_pass) begin
      need_newline_mark_next = row_has_output_next;
      run_char_next          = CHAR_NONE;
      run_length_next        = '0;
      need_pen_mark_next     = 1'b1;
    end
    if (dash) begin
      need_newline_mark_next = 1'b0;
      row_has_output_next    = 1'b0;
    end
  end

  assign push = accept && (any_flush || dash);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_char          <= CHAR_NONE;
      run_length        <= '0;
      need_newline_mark <= 1'b0;
      row_has_output    <= 1'b0;
      need_pen_mark     <= 1'b1;
      force_pending     <= 1'b0;
    end else if (accept) begin
      run_char          <= run_char_next;
      run_length        <= run_length_next;
      need_newline_mark <= need_newline_mark_next;
      row_has_output    <= row_has_output_next;
      need_pen_mark     <= need_pen_mark_next;
      force_pending     <= force_pending_next;
    end
  end

endmodule

// File: hw/rtl/srle_queue.sv
module srle_queue import srle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;
  logic            do_push, do_pop;

  assign full    = count == (PtrW+1)'(Depth);
  assign q_valid = count != '0;
  assign q_cmd   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/srle_back.sv
module srle_back import srle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  srle_byte_if.source stream
);

  typedef enum logic [4:0] {
    S_IDLE, S_NL, S_HASH, S_PEN_H, S_PEN_T, S_PEN_U, S_RUN, S_CHUNK,
    S_BANG, S_REP_H, S_REP_T, S_REP_U, S_REP_CH, S_LIT, S_DASH, S_DONE
  } phase_t;

  phase_t                 phase;
  logic                   nl, pm, dash, rsel;
  logic [PIX_W-1:0]       pen;
  logic [1:0]             rv;
  logic [1:0][CHAR_W-1:0] rch;
  logic [1:0][LEN_W-1:0]  rlen;
  logic [2:0]             cidx;
  logic [7:0]             pend_byte;
  logic                   pend_full;
  logic                   out_valid, out_last;
  logic [7:0]             out_byte;

  logic                   out_free, go, emit;
  logic [7:0]             ebyte, cur_char;
  logic [LEN_W-1:0]       cur_len;
  digits_t                pen_d, run_d;

  assign out_free = !out_valid || stream.ready;
  assign go       = out_free && (phase != S_IDLE);
  assign pop      = (phase == S_IDLE) && q_valid;

  assign stream.valid        = out_valid;
  assign stream.out_byte     = out_byte;
  assign stream.last_of_item = out_last;

  always_comb begin
    cur_len  = rlen[rsel];
    cur_char = {1'b0, rch[rsel]};
    pen_d    = dec3(pen);
    run_d    = dec3(cur_len[7:0]);
    emit     = 1'b0;
    ebyte    = cur_char;
    case (phase)
      S_NL: begin
        emit  = nl;
        ebyte = ASCII_DOLLAR;
      end
      S_HASH: begin
        emit  = pm;
        ebyte = ASCII_HASH;
      end
      S_PEN_H: begin
        emit  = pen_d.h != 4'd0;
        ebyte = digit_char(pen_d.h);
      end
      S_PEN_T: begin
        emit  = (pen_d.h != 4'd0) || (pen_d.t != 4'd0);
        ebyte = digit_char(pen_d.t);
      end
      S_PEN_U: begin
        emit  = 1'b1;
        ebyte = digit_char(pen_d.u);
      end
      S_CHUNK: begin
        emit = 1'b1;
        case (cidx)
          3'd0:    ebyte = ASCII_BANG;
          3'd1:    ebyte = ASCII_TWO;
          3'd2:    ebyte = ASCII_FIVE;
          3'd3:    ebyte = ASCII_FIVE;
          default: ebyte = cur_char;
        endcase
      end
      S_BANG: begin
        emit  = 1'b1;
        ebyte = ASCII_BANG;
      end
      S_REP_H: begin
        emit  = run_d.h != 4'd0;
        ebyte = digit_char(run_d.h);
      end
      S_REP_T: begin
        emit  = (run_d.h != 4'd0) || (run_d.t != 4'd0);
        ebyte = digit_char(run_d.t);
      end
      S_REP_U: begin
        emit  = 1'b1;
        ebyte = digit_char(run_d.u);
      end
      S_REP_CH, S_LIT: emit = 1'b1;
      S_DASH: begin
        emit  = dash;
        ebyte = ASCII_DASH;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= S_IDLE;
      pend_full <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && stream.ready) out_valid <= 1'b0;
      if (pop) begin
        nl    <= q_cmd.nl;
        pm    <= q_cmd.pm;
        pen   <= q_cmd.pen;
        rv    <= q_cmd.rv;
        rch   <= q_cmd.rch;
        rlen  <= q_cmd.rlen;
        dash  <= q_cmd.dash;
        rsel  <= 1'b0;
        cidx  <= '0;
        phase <= S_NL;
      end else if (go) begin
        // the held byte goes out once the next one shows up or the item ends
        if (emit) begin
          pend_byte <= ebyte;
          pend_full <= 1'b1;
          if (pend_full) begin
            out_valid <= 1'b1;
            out_byte  <= pend_byte;
            out_last  <= 1'b0;
          end
        end
        unique case (phase)
          S_NL:    phase <= S_HASH;
          S_HASH:  phase <= pm ? S_PEN_H : S_RUN;
          S_PEN_H: phase <= S_PEN_T;
          S_PEN_T: phase <= S_PEN_U;
          S_PEN_U: phase <= S_RUN;
          S_RUN: begin
            if (!rv[rsel]) begin
              if (rsel) phase <= S_DASH;
              else rsel <= 1'b1;
            end else if (cur_len >= CHUNK_LEN) begin
              cidx  <= '0;
              phase <= S_CHUNK;
            end else if (cur_len >= MIN_REPEAT) begin
              phase <= S_BANG;
            end else if (cur_len != '0) begin
              phase <= S_LIT;
            end else begin
              rv[rsel] <= 1'b0;
            end
          end
          S_CHUNK: begin
            if (cidx == 3'd4) begin
              rlen[rsel] <= cur_len - CHUNK_LEN;
              cidx       <= '0;
              phase      <= S_RUN;
            end else begin
              cidx <= cidx + 1'b1;
            end
          end
          S_BANG:  phase <= S_REP_H;
          S_REP_H: phase <= S_REP_T;
          S_REP_T: phase <= S_REP_U;
          S_REP_U: phase <= S_REP_CH;
          S_REP_CH: begin
            rv[rsel] <= 1'b0;
            phase    <= S_RUN;
          end
          S_LIT: begin
            rlen[rsel] <= cur_len - 1'b1;
            if (cur_len == 11'd1) phase <= S_RUN;
          end
          S_DASH: phase <= S_DONE;
          S_DONE: begin
            out_valid <= 1'b1;
            out_byte  <= pend_byte;
            out_last  <= 1'b1;
            pend_full <= 1'b0;
            phase     <= S_IDLE;
          end
          default: phase <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/sixel_row_run_length_encoder.sv
// sixel row encoder: takes one six-pixel column per request for one pen pass,
// builds the sixel character and streams run-length coded ascii bytes with
// the '$' / '#pen' pass prefix and the '-' row end. the front end takes a
// column every cycle while its four-entry command queue has room; columns
// that only extend a run produce nothing. the back end expands each queued
// command into bytes and takes the next command only once the current one is
// done, so the sustained rate is set by the byte sequencer. last_of_item marks
// the final byte of each column that produced output. transparent_pen sits at
// byte address 0 of the apb port and resets to 255; there is no clearing pass
// after reset.
module sixel_row_run_length_encoder import srle_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  srle_col_if.sink    col,
  srle_byte_if.source stream,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ADDR_TRANSPARENT_PEN = 2'd0;

  logic [PIX_W-1:0] transparent_pen;
  logic             q_full, q_push, q_pop, q_valid;
  cmd_t             push_cmd, q_cmd;

  // apb register: always ready, written on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transparent_pen <= 8'd255;
    end else if (psel && penable && pwrite && (paddr == ADDR_TRANSPARENT_PEN)) begin
      transparent_pen <= pwdata[PIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_TRANSPARENT_PEN) prdata = {24'b0, transparent_pen};
  end

  // front end: classify columns, track runs, queue byte-producing work
  srle_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk             (clk),
    .rst             (rst),
    .col             (col),
    .transparent_pen (transparent_pen),
    .q_full          (q_full),
    .push            (q_push),
    .cmd             (push_cmd)
  );

  // decouples column intake from byte output
  srle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // back end: expands each command into bytes while the stream is ready, one command at a time
  srle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (q_pop),
    .stream  (stream)
  );

endmodule
